### rtl/core/fpa_pkg.sv
// fpa_pkg: shared constants, item type and helpers for the fixed-point alu
// used by every module of the block; depends on nothing
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   // divider widths: numerator 2*|a|*2^F + |b|, denominator 2*|b|
   localparam int NUM_W = 33 + FRAC_BITS;
   localparam int DEN_W = 33;

   localparam logic [3:0] MODE_ADD      = 4'd0;
   localparam logic [3:0] MODE_SUB      = 4'd1;
   localparam logic [3:0] MODE_MUL      = 4'd2;
   localparam logic [3:0] MODE_DIV      = 4'd3;
   localparam logic [3:0] MODE_INC      = 4'd4;
   localparam logic [3:0] MODE_DEC      = 4'd5;
   localparam logic [3:0] MODE_MIN      = 4'd6;
   localparam logic [3:0] MODE_MAX      = 4'd7;
   localparam logic [3:0] MODE_TO_INT   = 4'd8;
   localparam logic [3:0] MODE_FROM_INT = 4'd9;

   typedef struct packed {
      logic signed [31:0] res;
      logic               sat;
   } clamp_type;

   typedef struct packed {
      logic [3:0]         mode;
      logic signed [31:0] res;
      logic               sat;
      logic               dz;
      logic               lt;
      logic               gt;
      logic               eq;
      logic               neg;
      logic signed [63:0] prod;
      logic [NUM_W-1:0]   num;
      logic [DEN_W-1:0]   den;
      logic [DEN_W-1:0]   rem;
   } item_type;

   // clamp a 33-bit signed sum to the word range
   function automatic clamp_type clamp33(input logic [32:0] s);
      clamp_type c;
      c.sat = s[32] != s[31];
      if (!c.sat) begin
         c.res = s[31:0];
      end else if (s[32]) begin
         c.res = 32'sh8000_0000;
      end else begin
         c.res = 32'sh7fff_ffff;
      end
      return c;
   endfunction

endpackage

### rtl/core/fixed_point_q24_8_alu.sv
// fixed_point_q24_8_alu: pipelined signed fixed-point alu, top level
// depends on fpa_pkg, fpa_prep, fpa_div_cell, fpa_finish
//
// Takes one item per cycle when not stalled and returns one result item per item
// in order. Each item passes a setup stage, a chain of NUM_W = 33 + FRAC_BITS
// division cells (41 for FRAC_BITS 8, one quotient bit per cell) and an output
// stage, each registered, for every mode. Each stage holds its item until the
// next one is free, so bubbles close up under stall.
module fixed_point_q24_8_alu (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_mode,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result,
   output logic               rsp_a_less,
   output logic               rsp_a_greater,
   output logic               rsp_a_equal,
   output logic               rsp_divide_by_zero,
   output logic               rsp_saturated
);
   localparam int N = fpa_pkg::NUM_W;

   logic              vld [0:N];
   logic              rdy [0:N];
   fpa_pkg::item_type itm [0:N];
   logic              up_ready;

   // setup stage
   fpa_prep u_prep (
      .clock(clock), .reset(reset),
      .up_valid(req_valid), .up_ready(up_ready),
      .mode(req_mode), .operand_a(req_operand_a), .operand_b(req_operand_b),
      .dn_valid(vld[0]), .dn_ready(rdy[0]), .dn_item(itm[0])
   );
   assign req_stall = !up_ready;

   // division cells
   for (genvar k = 0; k < N; k++) begin : g_cell
      fpa_div_cell u_cell (
         .clock(clock), .reset(reset),
         .up_valid(vld[k]), .up_ready(rdy[k]), .up_item(itm[k]),
         .dn_valid(vld[k+1]), .dn_ready(rdy[k+1]), .dn_item(itm[k+1])
      );
   end

   // output stage
   fpa_finish u_finish (
      .clock(clock), .reset(reset),
      .up_valid(vld[N]), .up_ready(rdy[N]), .up_item(itm[N]),
      .dn_valid(rsp_valid), .dn_ready(!rsp_stall),
      .result(rsp_result), .a_less(rsp_a_less), .a_greater(rsp_a_greater),
      .a_equal(rsp_a_equal), .divide_by_zero(rsp_divide_by_zero),
      .saturated(rsp_saturated)
   );

   // checks
   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_a_less, rsp_a_greater, rsp_a_equal}))
      else $error("compare flags not one-hot");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_result == 32'sd0 && !rsp_saturated))
      else $error("divide by zero result not cleared");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result)))
      else $error("stalled result item lost");
endmodule

### rtl/core/fpa_prep.sv
// fpa_prep: first stage, simple modes, compares, product and divider setup
// depends on fpa_pkg
module fpa_prep (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  logic [3:0]             mode,
   input  logic signed [31:0]     operand_a,
   input  logic signed [31:0]     operand_b,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output fpa_pkg::item_type      dn_item
);
   logic                valid_ff, valid_in;
   fpa_pkg::item_type   item_ff, item_in;
   logic [31:0]         amag, bmag;
   logic [32:0]         sum_s;
   fpa_pkg::clamp_type  cl;
   logic                load;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign valid_in = load || (valid_ff && !dn_ready);

   // operand magnitudes, compares, product, simple mode results and divider setup
   always_comb begin
      amag = operand_a[31] ? (~operand_a + 32'd1) : operand_a;
      bmag = operand_b[31] ? (~operand_b + 32'd1) : operand_b;
      item_in.mode = mode;
      item_in.lt   = operand_a < operand_b;
      item_in.gt   = operand_a > operand_b;
      item_in.eq   = operand_a == operand_b;
      item_in.dz   = (mode == fpa_pkg::MODE_DIV) && (operand_b == 32'sd0);
      item_in.neg  = operand_a[31] ^ operand_b[31];
      item_in.prod = operand_a * operand_b;
      item_in.num  = {amag, {fpa_pkg::FRAC_BITS{1'b0}}, 1'b0}
                     + fpa_pkg::NUM_W'(bmag);
      item_in.den  = {bmag, 1'b0};
      item_in.rem  = '0;
      sum_s        = '0;
      item_in.res  = '0;
      item_in.sat  = 1'b0;
      case (mode)
         fpa_pkg::MODE_ADD, fpa_pkg::MODE_SUB, fpa_pkg::MODE_INC, fpa_pkg::MODE_DEC: begin
            case (mode)
               fpa_pkg::MODE_ADD: sum_s = {operand_a[31], operand_a}
                                          + {operand_b[31], operand_b};
               fpa_pkg::MODE_SUB: sum_s = {operand_a[31], operand_a}
                                          - {operand_b[31], operand_b};
               fpa_pkg::MODE_INC: sum_s = {operand_a[31], operand_a} + 33'd1;
               default:           sum_s = {operand_a[31], operand_a} - 33'd1;
            endcase
            cl          = fpa_pkg::clamp33(sum_s);
            item_in.res = cl.res;
            item_in.sat = cl.sat;
         end
         fpa_pkg::MODE_MIN: item_in.res = item_in.lt ? operand_a : operand_b;
         fpa_pkg::MODE_MAX: item_in.res = item_in.gt ? operand_a : operand_b;
         fpa_pkg::MODE_TO_INT: item_in.res = operand_a >>> fpa_pkg::FRAC_BITS;
         fpa_pkg::MODE_FROM_INT: begin
            item_in.sat = !((&operand_a[31:31-fpa_pkg::FRAC_BITS])
                            || !(|operand_a[31:31-fpa_pkg::FRAC_BITS]));
            if (!item_in.sat) begin
               item_in.res = operand_a <<< fpa_pkg::FRAC_BITS;
            end else if (operand_a[31]) begin
               item_in.res = 32'sh8000_0000;
            end else begin
               item_in.res = 32'sh7fff_ffff;
            end
         end
         default: item_in.res = '0;
      endcase
      cl = fpa_pkg::clamp33(sum_s);
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;
endmodule

### rtl/core/fpa_div_cell.sv
// fpa_div_cell: one restoring division step per cell, item passes along
// depends on fpa_pkg
module fpa_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  fpa_pkg::item_type up_item,
   output logic              dn_valid,
   input  logic              dn_ready,
   output fpa_pkg::item_type dn_item
);
   logic                      valid_ff, valid_in;
   fpa_pkg::item_type         item_ff, item_in;
   logic [fpa_pkg::DEN_W:0]   rem_sh;
   logic                      ge;
   logic                      load;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign valid_in = load || (valid_ff && !dn_ready);

   // shift in next numerator bit, subtract when it fits, quotient bit enters lsb
   always_comb begin
      item_in     = up_item;
      rem_sh      = {up_item.rem, up_item.num[fpa_pkg::NUM_W-1]};
      ge          = rem_sh >= {1'b0, up_item.den};
      item_in.rem = ge ? fpa_pkg::DEN_W'(rem_sh - {1'b0, up_item.den})
                       : rem_sh[fpa_pkg::DEN_W-1:0];
      item_in.num = {up_item.num[fpa_pkg::NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;
endmodule

### rtl/core/fpa_finish.sv
// fpa_finish: rounding of products, clamp of products and quotients, output register
// depends on fpa_pkg
module fpa_finish (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  fpa_pkg::item_type  up_item,
   output logic               dn_valid,
   input  logic               dn_ready,
   output logic signed [31:0] result,
   output logic               a_less,
   output logic               a_greater,
   output logic               a_equal,
   output logic               divide_by_zero,
   output logic               saturated
);
   localparam logic [63:0] HALF = 64'd1 << (fpa_pkg::FRAC_BITS - 1);

   logic               valid_ff, valid_in;
   logic signed [31:0] res_ff, res_in;
   logic               sat_ff, sat_in;
   logic [2:0]         cmp_ff;
   logic               dz_ff;
   logic [63:0]        pmag, mag, lim;
   logic               neg;
   logic               load;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign valid_in = load || (valid_ff && !dn_ready);

   // magnitude, sign and clamp for mul and div
   always_comb begin
      pmag   = up_item.prod[63] ? (~up_item.prod + 64'd1) : up_item.prod;
      if (up_item.mode == fpa_pkg::MODE_MUL) begin
         mag = (pmag + HALF) >> fpa_pkg::FRAC_BITS;
         neg = up_item.prod[63];
      end else begin
         mag = 64'(up_item.num);
         neg = up_item.neg;
      end
      lim    = neg ? 64'h8000_0000 : 64'h7fff_ffff;
      res_in = up_item.res;
      sat_in = up_item.sat;
      if ((up_item.mode == fpa_pkg::MODE_MUL)
          || (up_item.mode == fpa_pkg::MODE_DIV && !up_item.dz)) begin
         sat_in = mag > lim;
         if (sat_in) begin
            res_in = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
         end else begin
            res_in = neg ? (~mag[31:0] + 32'd1) : mag[31:0];
         end
      end else if (up_item.mode == fpa_pkg::MODE_DIV) begin
         res_in = '0;
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
         dz_ff  <= up_item.dz;
         cmp_ff <= {up_item.lt, up_item.gt, up_item.eq};
      end
   end

   assign dn_valid       = valid_ff;
   assign result         = res_ff;
   assign saturated      = sat_ff;
   assign divide_by_zero = dz_ff;
   assign a_less         = cmp_ff[2];
   assign a_greater      = cmp_ff[1];
   assign a_equal        = cmp_ff[0];
endmodule

### dv/fpa_checker.sv
// fpa_checker: watches the request and response channels of the fixed-point alu,
// predicts each result and compares it field by field; depends on fpa_pkg
`timescale 1ns / 1ps

module fpa_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [3:0]         req_mode,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_result,
   input  logic               rsp_a_less,
   input  logic               rsp_a_greater,
   input  logic               rsp_a_equal,
   input  logic               rsp_divide_by_zero,
   input  logic               rsp_saturated,
   output int                 fail_count,
   output int                 pending
);

   typedef struct {
      logic signed [31:0] result;
      logic               lt;
      logic               gt;
      logic               eq;
      logic               dz;
      logic               sat;
   } alu_out_type;

   alu_out_type expected_q[$];

   // saturate a wide value to the word range
   function automatic logic signed [31:0] sat_word(input logic signed [127:0] v,
                                                   inout logic s);
      if (v > 128'sd2147483647) begin
         s = 1'b1;
         return 32'sh7fff_ffff;
      end
      if (v < -128'sd2147483648) begin
         s = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // compute the expected result of one item
   function automatic alu_out_type alu_predict(input logic [3:0] mode,
                                               input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      alu_out_type o;
      logic signed [127:0] wa, wb, p, q;
      logic [127:0] m, n, d;
      logic s;
      wa = a;
      wb = b;
      s = 1'b0;
      o.dz = 1'b0;
      o.result = '0;
      case (mode)
         fpa_pkg::MODE_ADD: o.result = sat_word(wa + wb, s);
         fpa_pkg::MODE_SUB: o.result = sat_word(wa - wb, s);
         fpa_pkg::MODE_MUL: begin
            p = wa * wb;
            m = p < 0 ? -p : p;
            m = (m + (128'd1 << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
            q = m;
            o.result = sat_word(p < 0 ? -q : q, s);
         end
         fpa_pkg::MODE_DIV: begin
            if (b == 0) begin
               o.dz = 1'b1;
            end else begin
               n = (wa < 0 ? -wa : wa) << fpa_pkg::FRAC_BITS;
               d = wb < 0 ? -wb : wb;
               q = (2 * n + d) / (2 * d);
               o.result = sat_word(((a < 0) != (b < 0)) ? -q : q, s);
            end
         end
         fpa_pkg::MODE_INC: o.result = sat_word(wa + 1, s);
         fpa_pkg::MODE_DEC: o.result = sat_word(wa - 1, s);
         fpa_pkg::MODE_MIN: o.result = a < b ? a : b;
         fpa_pkg::MODE_MAX: o.result = a > b ? a : b;
         fpa_pkg::MODE_TO_INT: o.result = a >>> fpa_pkg::FRAC_BITS;
         fpa_pkg::MODE_FROM_INT:
            o.result = sat_word(wa * (128'sd1 <<< fpa_pkg::FRAC_BITS), s);
         default: o.result = '0;
      endcase
      o.sat = s;
      o.lt = a < b;
      o.gt = a > b;
      o.eq = a == b;
      return o;
   endfunction

   // predict on request, compare on response
   always @(posedge clock) begin
      alu_out_type e;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_q.push_back(alu_predict(req_mode, req_operand_a, req_operand_b));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result item %h", rsp_result);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (rsp_result !== e.result || rsp_a_less !== e.lt
                   || rsp_a_greater !== e.gt || rsp_a_equal !== e.eq
                   || rsp_divide_by_zero !== e.dz || rsp_saturated !== e.sat) begin
                  fail_count <= fail_count + 1;
                  if (rsp_result !== e.result)
                     $error("result exp %h got %h", e.result, rsp_result);
                  if (rsp_a_less !== e.lt)
                     $error("a_less exp %b got %b", e.lt, rsp_a_less);
                  if (rsp_a_greater !== e.gt)
                     $error("a_greater exp %b got %b", e.gt, rsp_a_greater);
                  if (rsp_a_equal !== e.eq)
                     $error("a_equal exp %b got %b", e.eq, rsp_a_equal);
                  if (rsp_divide_by_zero !== e.dz)
                     $error("divide_by_zero exp %b got %b", e.dz, rsp_divide_by_zero);
                  if (rsp_saturated !== e.sat)
                     $error("saturated exp %b got %b", e.sat, rsp_saturated);
               end
            end
         end
      end
      // items still waiting for their result
      pending <= expected_q.size();
   end

endmodule

### dv/tb.sv
// tb: stimulus and verdict for the fixed-point alu
// depends on fpa_pkg, fpa_checker and the fixed_point_q24_8_alu rtl
`timescale 1ns / 1ps

module tb;

   localparam int LATENCY   = fpa_pkg::NUM_W + 2;
   localparam int N_RANDOM  = 1700;
   localparam int MAX_CYCLE = 400000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [3:0]         req_mode;
   logic signed [31:0] req_operand_a;
   logic signed [31:0] req_operand_b;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_result;
   logic               rsp_a_less;
   logic               rsp_a_greater;
   logic               rsp_a_equal;
   logic               rsp_divide_by_zero;
   logic               rsp_saturated;
   int                 fail_count;
   int                 pending;
   int                 cycle_count = 0;
   bit                 quiet;

   fixed_point_q24_8_alu u_top (.*);

   fpa_checker u_checker (.*);

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("FAIL");
         $finish;
      end
   end

   // response stall in random bursts
   always @(negedge clock) begin
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         rsp_stall <= 1'b1;
         repeat (gap) @(negedge clock);
      end
      rsp_stall <= 1'b0;
   end

   // random operand biased toward edges
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff - $urandom_range(0, 3);
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return $urandom_range(0, 4) - 2;
         3: return $signed($urandom_range(0, 2048)) - 1024;
         4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         default: return $urandom();
      endcase
   endfunction

   // present one item and wait for its acceptance
   task automatic send_item(input logic [3:0] mode, input logic [31:0] a,
                            input logic [31:0] b);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [31:0] edge_val[6];
      logic [3:0] m;
      quiet         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mode      = fpa_pkg::MODE_ADD;
      req_operand_a = '0;
      req_operand_b = '0;
      edge_val = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h100, 32'h80};
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed: each mode on extremes, zero divisor, unused modes
      for (int i = 0; i < 16; i++) begin
         m = 4'(i);
         send_item(m, edge_val[i % 6], edge_val[(i + 1) % 6]);
      end
      send_item(fpa_pkg::MODE_DIV, 32'h0000_0180, 32'h0);
      send_item(fpa_pkg::MODE_DIV, 32'h7fff_ffff, 32'h0000_0001);
      send_item(fpa_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000);
      send_item(fpa_pkg::MODE_MUL, 32'h0000_0180, 32'h0000_0080);
      send_item(fpa_pkg::MODE_MUL, 32'hffff_fe80, 32'h0000_0080);
      send_item(fpa_pkg::MODE_INC, 32'h7fff_ffff, 32'h7fff_ffff);
      send_item(fpa_pkg::MODE_DEC, 32'h8000_0000, 32'h0);
      send_item(fpa_pkg::MODE_TO_INT, 32'hffff_ff01, 32'h0);
      send_item(fpa_pkg::MODE_FROM_INT, 32'h0080_0000, 32'h0);

      // random items, last part with no idling
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM - 200) quiet = 1'b1;
         m = 4'(($urandom_range(0, 19) == 0) ? $urandom_range(10, 15)
                                             : $urandom_range(0, 9));
         send_item(m, pick_operand(), ($urandom_range(0, 15) == 0) ? 32'h0
                                                                  : pick_operand());
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
